// ===== design/matrix_scan_order_reorderer_top_defines.svh =====
// Assertion macros used by the matrix scan order reorderer checker
`ifndef MATRIX_SCAN_ORDER_REORDERER_TOP_DEFINES_SVH
`define MATRIX_SCAN_ORDER_REORDERER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MSOR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MSOR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/msor_pkg.sv =====
// Package with shared constants, codes and control types of the scan order reorderer
`timescale 1ns / 1ps

package msor_pkg;

  localparam int unsigned SIDE_LIMIT     = 8;
  localparam int unsigned MAX_SIDE_DEF   = 8;
  localparam int unsigned DATA_WIDTH_DEF = 16;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned COORD_W    = 3;
  localparam int unsigned SIDE_W     = 4;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CNT_W      = $clog2(SIDE_LIMIT * SIDE_LIMIT + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE = 1'b0,
    CFG_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    SCAN_DIAG_RIGHT    = 2'd0,
    SCAN_DIAG_LEFT     = 2'd1,
    SCAN_SPIRAL_CENTER = 2'd2,
    SCAN_SPIRAL_CORNER = 2'd3
  } scan_mode_e;

  typedef struct packed {
    logic load;
    logic launch;
    logic step;
    logic last;
  } msor_cmd_t;

  typedef struct packed {
    logic             fill_done;
    logic [CNT_W-1:0] scan_total;
  } msor_status_t;

endpackage

// ===== design/msor_ctrl.sv =====
// Controller state machine: load phase and scan emission sequencing
`timescale 1ns / 1ps

module msor_ctrl import msor_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  msor_status_t status_i,
  output msor_cmd_t    cmd_o,
  output logic         busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (status_i.fill_done) begin
            cmd_o.launch = 1'b1;
            cnt_d        = '0;
            state_d      = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.step = 1'b1;
        cmd_o.last = (cnt_q == (status_i.scan_total - CNT_W'(1)));
        cnt_d      = cnt_q + CNT_W'(1);
        if (cmd_o.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q == ST_EMIT);

endmodule

// ===== design/msor_dp.sv =====
// Datapath: configuration, element store, scan coordinate generator and result registers
`timescale 1ns / 1ps

module msor_dp import msor_pkg::*; #(
  parameter int unsigned MAX_SIDE   = MAX_SIDE_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [VALUE_W-1:0]    element_value_i,
  input  msor_cmd_t             cmd_i,
  output msor_status_t          status_o,
  output logic                  out_strobe_o,
  output logic [VALUE_W-1:0]    out_value_o,
  output logic [COORD_W-1:0]    out_row_o,
  output logic [COORD_W-1:0]    out_col_o,
  output logic                  is_last_o
);

  localparam int unsigned DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  logic [SIDE_W-1:0]      side_q;
  scan_mode_e             mode_q;
  logic [SIDE_W-1:0]      n_live;
  logic [2*SIDE_W-1:0]    live_sq;
  logic [CNT_W-1:0]       live_total;
  logic [CNT_W-1:0]       load_count_q;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   fill_done;

  logic [STORE_W-1:0]     mem [DEPTH];
  logic [STORE_W-1:0]     rd_q;
  logic [AW-1:0]          raddr;
  logic [COORD_W+SIDE_W-1:0] addr_full;

  logic [SIDE_W-1:0]      n_q;
  scan_mode_e             smode_q;
  logic [2*SIDE_W-1:0]    scan_sq;

  logic [COORD_W-1:0]     r_q, r_d, c_q, c_d, sr_q, sr_d, sc_q, sc_d;
  logic [COORD_W-1:0]     top_q, top_d, bot_q, bot_d, lf_q, lf_d, rt_q, rt_d;
  dir_e                   dir_q, dir_d;
  logic [SIDE_W-1:0]      run_q, run_d, stp_q, stp_d, stp_inc;
  logic [COORD_W-1:0]     nm1, nm1_live, mid_live;

  logic                   strobe_q, last_q;
  logic [COORD_W-1:0]     row_q, col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_W'(3);
      mode_q <= SCAN_DIAG_RIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SIDE: side_q <= cfg_wdata_i[SIDE_W-1:0];
        CFG_MODE: mode_q <= scan_mode_e'(cfg_wdata_i[MODE_W-1:0]);
        default:  side_q <= side_q;
      endcase
    end
  end

  always_comb begin
    priority if (side_q == '0) begin
      n_live = SIDE_W'(1);
    end else if (side_q > SIDE_W'(MAX_SIDE)) begin
      n_live = SIDE_W'(MAX_SIDE);
    end else begin
      n_live = side_q;
    end
  end

  assign live_sq    = n_live * n_live;
  assign live_total = CNT_W'(live_sq);
  assign cnt_inc    = load_count_q + CNT_W'(1);
  assign fill_done  = (cnt_inc >= live_total);

  assign scan_sq             = n_q * n_q;
  assign status_o.fill_done  = fill_done;
  assign status_o.scan_total = CNT_W'(scan_sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
    end else if (cmd_i.load) begin
      load_count_q <= fill_done ? '0 : cnt_inc;
    end
  end

  // element store: one write port for loads, one registered read port for the scan
  assign addr_full = r_q * n_q + c_q;
  assign raddr     = addr_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (load_count_q < CNT_W'(DEPTH))) begin
      mem[load_count_q[AW-1:0]] <= element_value_i[STORE_W-1:0];
    end
    if (cmd_i.step) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= SIDE_W'(1);
      smode_q <= SCAN_DIAG_RIGHT;
    end else if (cmd_i.launch) begin
      n_q     <= n_live;
      smode_q <= mode_q;
    end
  end

  assign nm1      = COORD_W'(n_q - SIDE_W'(1));
  assign nm1_live = COORD_W'(n_live - SIDE_W'(1));
  assign mid_live = nm1_live >> 1;
  assign stp_inc  = stp_q + SIDE_W'(1);

  always_comb begin
    r_d   = r_q;
    c_d   = c_q;
    sr_d  = sr_q;
    sc_d  = sc_q;
    top_d = top_q;
    bot_d = bot_q;
    lf_d  = lf_q;
    rt_d  = rt_q;
    dir_d = dir_q;
    run_d = run_q;
    stp_d = stp_q;
    if (cmd_i.launch) begin
      sr_d  = '0;
      top_d = '0;
      lf_d  = '0;
      bot_d = nm1_live;
      rt_d  = nm1_live;
      dir_d = DIR_RIGHT;
      run_d = SIDE_W'(1);
      stp_d = '0;
      unique case (mode_q)
        SCAN_DIAG_RIGHT: begin
          r_d  = '0;
          c_d  = nm1_live;
          sc_d = nm1_live;
        end
        SCAN_DIAG_LEFT: begin
          r_d  = '0;
          c_d  = '0;
          sc_d = '0;
        end
        SCAN_SPIRAL_CENTER: begin
          r_d = mid_live;
          c_d = mid_live;
        end
        SCAN_SPIRAL_CORNER: begin
          r_d = '0;
          c_d = '0;
        end
        default: begin
          r_d = '0;
          c_d = '0;
        end
      endcase
    end else if (cmd_i.step) begin
      unique case (smode_q)
        SCAN_DIAG_RIGHT: begin
          if ((r_q == nm1) || (c_q == nm1)) begin
            if (sc_q != '0) begin
              sr_d = '0;
              sc_d = sc_q - COORD_W'(1);
            end else begin
              sr_d = sr_q + COORD_W'(1);
              sc_d = '0;
            end
            r_d = sr_d;
            c_d = sc_d;
          end else begin
            r_d = r_q + COORD_W'(1);
            c_d = c_q + COORD_W'(1);
          end
        end
        SCAN_DIAG_LEFT: begin
          if ((r_q == nm1) || (c_q == '0)) begin
            if (sc_q != nm1) begin
              sr_d = '0;
              sc_d = sc_q + COORD_W'(1);
            end else begin
              sr_d = sr_q + COORD_W'(1);
              sc_d = nm1;
            end
            r_d = sr_d;
            c_d = sc_d;
          end else begin
            r_d = r_q + COORD_W'(1);
            c_d = c_q - COORD_W'(1);
          end
        end
        SCAN_SPIRAL_CENTER: begin
          unique case (dir_q)
            DIR_RIGHT: c_d = c_q + COORD_W'(1);
            DIR_DOWN:  r_d = r_q + COORD_W'(1);
            DIR_LEFT:  c_d = c_q - COORD_W'(1);
            DIR_UP:    r_d = r_q - COORD_W'(1);
            default:   c_d = c_q;
          endcase
          if (stp_inc == run_q) begin
            stp_d = '0;
            unique case (dir_q)
              DIR_RIGHT: dir_d = DIR_DOWN;
              DIR_DOWN: begin
                dir_d = DIR_LEFT;
                run_d = run_q + SIDE_W'(1);
              end
              DIR_LEFT:  dir_d = DIR_UP;
              DIR_UP: begin
                dir_d = DIR_RIGHT;
                run_d = run_q + SIDE_W'(1);
              end
              default:   dir_d = DIR_RIGHT;
            endcase
          end else begin
            stp_d = stp_inc;
          end
        end
        SCAN_SPIRAL_CORNER: begin
          unique case (dir_q)
            DIR_RIGHT: begin
              if (c_q < rt_q) begin
                c_d = c_q + COORD_W'(1);
              end else begin
                dir_d = DIR_DOWN;
                r_d   = r_q + COORD_W'(1);
                top_d = top_q + COORD_W'(1);
              end
            end
            DIR_DOWN: begin
              if (r_q < bot_q) begin
                r_d = r_q + COORD_W'(1);
              end else begin
                dir_d = DIR_LEFT;
                c_d   = c_q - COORD_W'(1);
                rt_d  = rt_q - COORD_W'(1);
              end
            end
            DIR_LEFT: begin
              if (c_q > lf_q) begin
                c_d = c_q - COORD_W'(1);
              end else begin
                dir_d = DIR_UP;
                r_d   = r_q - COORD_W'(1);
                bot_d = bot_q - COORD_W'(1);
              end
            end
            DIR_UP: begin
              if (r_q > top_q) begin
                r_d = r_q - COORD_W'(1);
              end else begin
                dir_d = DIR_RIGHT;
                c_d   = c_q + COORD_W'(1);
                lf_d  = lf_q + COORD_W'(1);
              end
            end
            default: dir_d = DIR_RIGHT;
          endcase
        end
        default: begin
          r_d = r_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    c_q   <= c_d;
    sr_q  <= sr_d;
    sc_q  <= sc_d;
    top_q <= top_d;
    bot_q <= bot_d;
    lf_q  <= lf_d;
    rt_q  <= rt_d;
    dir_q <= dir_d;
    run_q <= run_d;
    stp_q <= stp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= cmd_i.step;
      last_q   <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      row_q <= r_q;
      col_q <= c_q;
    end
  end

  assign out_strobe_o = strobe_q;
  assign out_value_o  = VALUE_W'(rd_q);
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign is_last_o    = last_q;

endmodule

// ===== design/matrix_scan_order_reorderer_top.sv =====
// Top level of the matrix scan order reorderer: controller and datapath
//
//  channel   direction  transfer when             payload
//  input     in         start && !busy            element_value_i
//  config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//  result    out        out_strobe_o (one cycle)  out_value_o, out_row_o, out_col_o, is_last_o
//
// Elements are taken one per cycle while busy is low; the side*side-th one starts the scan.
// The scan issues one store read per cycle while busy is high; results follow the final
// transfer through the emit state and the result registers, one per cycle, no gaps.
// The last result shows in the cycle busy falls. Results cannot be stalled.
// Reset sets side to 3, scan mode to right diagonals and the load count to zero;
// store contents are undefined until loaded.
`timescale 1ns / 1ps

module matrix_scan_order_reorderer_top import msor_pkg::*; #(
  parameter int unsigned MAX_SIDE   = MAX_SIDE_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_W-1:0]    element_value_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  out_strobe_o,
  output logic [VALUE_W-1:0]    out_value_o,
  output logic [COORD_W-1:0]    out_row_o,
  output logic [COORD_W-1:0]    out_col_o,
  output logic                  is_last_o
);

  msor_cmd_t    cmd;
  msor_status_t status;

  msor_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  msor_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_strobe_o    (out_strobe_o),
    .out_value_o     (out_value_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .is_last_o       (is_last_o)
  );

endmodule

// ===== design/msor_checker.sv =====
// Port-level checker for the matrix scan order reorderer, bound to the top level
`timescale 1ns / 1ps
`include "matrix_scan_order_reorderer_top_defines.svh"

module msor_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic out_strobe_o,
  input logic is_last_o
);

  `MSOR_ASSERT_IMP(a_last_has_strobe, clk_i, rst_ni, is_last_o, out_strobe_o, "last flag without result strobe")
  `MSOR_ASSERT_IMP(a_mid_scan_busy, clk_i, rst_ni, out_strobe_o && !is_last_o, busy, "non-final result while not busy")
  `MSOR_ASSERT_NXT(a_gap_after_last, clk_i, rst_ni, is_last_o, !out_strobe_o, "result right after the final one")
  `MSOR_ASSERT_IMP(a_busy_after_load, clk_i, rst_ni, $rose(busy), $past(start), "scan started without an element transfer")

endmodule

bind matrix_scan_order_reorderer_top msor_checker u_msor_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .out_strobe_o (out_strobe_o),
  .is_last_o    (is_last_o)
);

// ===== test/tb_matrix_scan_order_reorderer_top.sv =====
// Testbench for the matrix scan order reorderer: directed and random matrices checked per result
`timescale 1ns / 1ps

module tb_matrix_scan_order_reorderer_top;
  import msor_pkg::*;

  localparam int unsigned CELL_COUNT   = SIDE_LIMIT * SIDE_LIMIT;
  localparam int unsigned ITEM_TARGET  = 410;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned SETTLE_TICKS = 4;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } scan_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  start           = 1'b0;
  logic                  busy;
  logic [VALUE_W-1:0]    element_value_i = '0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                  out_strobe_o;
  logic [VALUE_W-1:0]    out_value_o;
  logic [COORD_W-1:0]    out_row_o;
  logic [COORD_W-1:0]    out_col_o;
  logic                  is_last_o;

  // mirror of the block state
  logic [SIDE_W-1:0]  side_reg = 4'd3;
  scan_mode_e         mode_reg = SCAN_DIAG_RIGHT;
  logic [VALUE_W-1:0] element_store [CELL_COUNT];
  int unsigned        fill_count = 0;

  scan_result_t pending_scan_q [$];
  int unsigned  items_sent = 0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  bit           quiet = 1'b0;

  matrix_scan_order_reorderer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .element_value_i(element_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_strobe_o   (out_strobe_o),
    .out_value_o    (out_value_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .is_last_o      (is_last_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int clamp_side(input logic [SIDE_W-1:0] s);
    if (s == 0) return 1;
    if (s > SIDE_LIMIT) return SIDE_LIMIT;
    return int'(s);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s at cycle %0d: got %0h expected %0h",
             what, cycle_count, got, want);
    error_count++;
  endtask

  task automatic push_cell(input int n, input int base, input int r, input int c);
    scan_result_t res;
    if (pending_scan_q.size() - base >= n * n) return;
    if (r < 0 || c < 0 || r >= n || c >= n) return;
    res.value = element_store[r * n + c];
    res.row   = COORD_W'(r);
    res.col   = COORD_W'(c);
    res.last  = 1'b0;
    pending_scan_q.push_back(res);
  endtask

  // append the scan order of the full matrix behind any result still queued
  task automatic emit_scan(input int n);
    int r;
    int c;
    int run;
    int top;
    int bot;
    int lf;
    int rt;
    int base;
    base = pending_scan_q.size();
    case (mode_reg)
      SCAN_DIAG_RIGHT: begin
        for (int d = 0; d < n; d++)
          for (int j = 0; j <= d; j++) push_cell(n, base, j, n - 1 - d + j);
        for (int d = 1; d < n; d++)
          for (int j = 0; j <= n - 1 - d; j++) push_cell(n, base, d + j, j);
      end
      SCAN_DIAG_LEFT: begin
        for (int d = 0; d < n; d++)
          for (int j = 0; j <= d; j++) push_cell(n, base, j, d - j);
        for (int d = 1; d < n; d++)
          for (int j = 0; j <= n - 1 - d; j++) push_cell(n, base, d + j, n - 1 - j);
      end
      SCAN_SPIRAL_CENTER: begin
        r = (n - 1) / 2;
        c = r;
        run = 1;
        push_cell(n, base, r, c);
        while (pending_scan_q.size() - base < n * n) begin
          for (int i = 0; i < run; i++) begin c++; push_cell(n, base, r, c); end
          for (int i = 0; i < run; i++) begin r++; push_cell(n, base, r, c); end
          run++;
          for (int i = 0; i < run; i++) begin c--; push_cell(n, base, r, c); end
          for (int i = 0; i < run; i++) begin r--; push_cell(n, base, r, c); end
          run++;
        end
      end
      default: begin
        top = 0;
        bot = n - 1;
        lf = 0;
        rt = n - 1;
        while (pending_scan_q.size() - base < n * n && top <= bot && lf <= rt) begin
          for (int j = lf; j <= rt; j++) push_cell(n, base, top, j);
          top++;
          for (int i = top; i <= bot; i++) push_cell(n, base, i, rt);
          rt--;
          if (top <= bot) begin
            for (int j = rt; j >= lf; j--) push_cell(n, base, bot, j);
            bot--;
          end
          if (lf <= rt) begin
            for (int i = bot; i >= top; i--) push_cell(n, base, i, lf);
            lf++;
          end
        end
      end
    endcase
    pending_scan_q[pending_scan_q.size() - 1].last = 1'b1;
  endtask

  task automatic accept_element(input logic [VALUE_W-1:0] value);
    int n;
    n = clamp_side(side_reg);
    element_store[fill_count] = value;
    fill_count++;
    items_sent++;
    if (fill_count >= n * n) begin
      fill_count = 0;
      emit_scan(n);
    end
  endtask

  task automatic send_element(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    start <= 1'b1;
    element_value_i <= value;
    do @(posedge clk_i); while (busy);
    accept_element(value);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      element_value_i <= VALUE_W'($urandom_range(0, 65535));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every expected result has come and the block has settled
  task automatic drain();
    start <= 1'b0;
    while (pending_scan_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_SIDE) side_reg = data;
    else mode_reg = scan_mode_e'(data[MODE_W-1:0]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_mode(input scan_mode_e mode);
    write_register(CFG_MODE, {(CFG_DATA_W - MODE_W)'($urandom_range(0, 3)), mode});
  endtask

  task automatic fill_matrix();
    int n;
    n = clamp_side(side_reg);
    for (int k = 0; k < n * n; k++) send_element(VALUE_W'($urandom_range(0, 65535)));
  endtask

  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && out_strobe_o) begin
      if (pending_scan_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_value_o, 0);
      end else begin
        want = pending_scan_q.pop_front();
        if (out_value_o !== want.value) report_mismatch("value", out_value_o, want.value);
        if (out_row_o !== want.row) report_mismatch("row", out_row_o, want.row);
        if (out_col_o !== want.col) report_mismatch("col", out_col_o, want.col);
        if (is_last_o !== want.last) report_mismatch("last", is_last_o, want.last);
      end
    end
  end

  task automatic test_reset_defaults();
    send_element(16'h0000);
    send_element(16'hFFFF);
    send_element(16'h5555);
    send_element(16'hAAAA);
    send_element(16'h8001);
    for (int k = 0; k < 4; k++) send_element(VALUE_W'($urandom_range(0, 65535)));
    drain();
  endtask

  task automatic test_side_zero();
    write_register(CFG_SIDE, 4'd0);
    send_element(16'h7FFE);
    drain();
  endtask

  task automatic test_scan_modes();
    write_register(CFG_SIDE, 4'd2);
    write_mode(SCAN_DIAG_LEFT);
    fill_matrix();
    drain();
    write_mode(SCAN_SPIRAL_CENTER);
    fill_matrix();
    drain();
  endtask

  task automatic test_midload_changes();
    write_register(CFG_SIDE, 4'd3);
    write_mode(SCAN_DIAG_RIGHT);
    for (int k = 0; k < 5; k++) send_element(VALUE_W'($urandom_range(0, 65535)));
    drain();
    write_register(CFG_SIDE, 4'd2);
    send_element(VALUE_W'($urandom_range(0, 65535)));
    drain();
    for (int k = 0; k < 2; k++) send_element(VALUE_W'($urandom_range(0, 65535)));
    drain();
    write_mode(SCAN_SPIRAL_CORNER);
    for (int k = 0; k < 2; k++) send_element(VALUE_W'($urandom_range(0, 65535)));
    drain();
  endtask

  task automatic test_random_matrices();
    int unsigned roll;
    int n;
    logic [SIDE_W-1:0] side_pick;
    for (int m = 0; m < 4; m++) begin
      write_register(CFG_SIDE, (m == 0) ? 4'd15 : (m == 1) ? 4'd9 : 4'd8);
      write_mode(scan_mode_e'(m));
      quiet = ($urandom_range(0, 3) == 0);
      fill_matrix();
      drain();
    end
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) side_pick = SIDE_W'($urandom_range(1, 4));
      else if (roll == 7) side_pick = SIDE_W'($urandom_range(5, 8));
      else if (roll == 8) side_pick = 4'd0;
      else side_pick = SIDE_W'($urandom_range(9, 15));
      write_register(CFG_SIDE, side_pick);
      write_mode(scan_mode_e'($urandom_range(0, 3)));
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) fill_matrix();
      n = clamp_side(side_reg);
      if ($urandom_range(0, 4) == 0 && n > 1) begin
        repeat ($urandom_range(1, n * n - 1)) send_element(VALUE_W'($urandom_range(0, 65535)));
        drain();
        if ($urandom_range(0, 1) == 0)
          write_register(CFG_SIDE, SIDE_W'($urandom_range(1, 8)));
        else
          write_mode(scan_mode_e'($urandom_range(0, 3)));
        while (fill_count != 0) send_element(VALUE_W'($urandom_range(0, 65535)));
      end
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_side_zero();
    test_scan_modes();
    test_midload_changes();
    test_random_matrices();
    drain();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== matrix_scan_order_reorderer_top.f =====
+incdir+design
design/msor_pkg.sv
design/msor_ctrl.sv
design/msor_dp.sv
design/matrix_scan_order_reorderer_top.sv
design/msor_checker.sv
test/tb_matrix_scan_order_reorderer_top.sv
